### hw/rtl/tla_pkg.sv
// shared types, constants and lookup functions for the tank level averaging alarm
`timescale 1ns / 1ps
`default_nettype none

package tla_pkg;

	localparam int PROBE_W  = 9;
	localparam int LEVEL_W  = 7;
	localparam int SEG_W    = 16;
	localparam int DIGIT_W  = 4;
	localparam int S_DATA_W = 16;
	localparam int M_DATA_W = 40;

	localparam logic [LEVEL_W-1:0] LEVEL_MAX    = 7'd99;
	localparam logic [LEVEL_W-1:0] THRESH_RESET = 7'd20;

	// combinational result of one word, before segment decode
	typedef struct packed {
		logic [LEVEL_W-1:0] level;
		logic               alarm;
		logic               updated;
	} avg_result_t;

	// highest active probe wins, no probe means empty
	function automatic logic [LEVEL_W-1:0] encode_level(input logic [PROBE_W-1:0] bits);
		logic [LEVEL_W-1:0] lvl;
		begin
			if (bits[8])      lvl = 7'd99;
			else if (bits[7]) lvl = 7'd90;
			else if (bits[6]) lvl = 7'd80;
			else if (bits[5]) lvl = 7'd60;
			else if (bits[4]) lvl = 7'd50;
			else if (bits[3]) lvl = 7'd40;
			else if (bits[2]) lvl = 7'd20;
			else if (bits[1]) lvl = 7'd10;
			else if (bits[0]) lvl = 7'd5;
			else              lvl = 7'd0;
			return lvl;
		end
	endfunction

	// port pattern of one decimal digit
	function automatic logic [SEG_W-1:0] seg_pattern(input logic [DIGIT_W-1:0] digit);
		logic [SEG_W-1:0] pat;
		begin
			case (digit)
				4'd0: begin
					pat = 16'h8000;
				end
				4'd1: begin
					pat = 16'hF330;
				end
				4'd2: begin
					pat = 16'h4BDF;
				end
				4'd3: begin
					pat = 16'h63DF;
				end
				4'd4: begin
					pat = 16'h33FF;
				end
				4'd5: begin
					pat = 16'h26DF;
				end
				4'd6: begin
					pat = 16'h07DF;
				end
				4'd7: begin
					pat = 16'hF3DF;
				end
				4'd8: begin
					pat = 16'h03DF;
				end
				4'd9: begin
					pat = 16'h23DF;
				end
				default: begin
					pat = 16'h8000;
				end
			endcase
			return pat;
		end
	endfunction

endpackage

`default_nettype wire

### hw/rtl/tla_accum.sv
// window accumulator, average by reciprocal multiply and alarm compare
`timescale 1ns / 1ps
`default_nettype none

module tla_accum #(
	parameter int WINDOW_SAMPLES = 25
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        step,
	input  wire logic [tla_pkg::LEVEL_W-1:0] sample_level,
	input  wire logic [tla_pkg::LEVEL_W-1:0] threshold,
	output tla_pkg::avg_result_t             result
);
	import tla_pkg::*;

	localparam int IDX_W     = $clog2(WINDOW_SAMPLES + 1);
	localparam int SUM_W     = $clog2(99 * WINDOW_SAMPLES + 1);
	localparam int DIV_SHIFT = 20;
	localparam int MULT_W    = DIV_SHIFT + 1;
	localparam int PROD_W    = SUM_W + MULT_W;
	localparam logic [MULT_W-1:0] DIV_MULT =
		MULT_W'((2 ** DIV_SHIFT + WINDOW_SAMPLES - 1) / WINDOW_SAMPLES);

	logic [IDX_W-1:0]   index_q;
	logic [SUM_W-1:0]   sum_q;
	logic [LEVEL_W-1:0] level_q;
	logic               alarm_q;
	logic               window_done;
	logic [PROD_W-1:0]  product;
	logic [LEVEL_W-1:0] avg;

	assign window_done = (index_q == IDX_W'(WINDOW_SAMPLES));

	// sum stays far below 2^20 / window, so the scaled reciprocal is exact
	assign product = PROD_W'(sum_q) * PROD_W'(DIV_MULT);
	assign avg     = product[DIV_SHIFT +: LEVEL_W];

	always_comb begin
		result.level   = window_done ? avg : level_q;
		result.alarm   = window_done ? (avg <= threshold) : alarm_q;
		result.updated = window_done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			index_q <= '0;
			sum_q   <= '0;
			level_q <= '0;
			alarm_q <= 1'b0;
		end else if (step) begin
			if (window_done) begin
				index_q <= '0;
				sum_q   <= '0;
				level_q <= avg;
				alarm_q <= result.alarm;
			end else begin
				index_q <= index_q + IDX_W'(1);
				sum_q   <= sum_q + SUM_W'(sample_level);
			end
		end
	end

endmodule

`default_nettype wire

### hw/rtl/tla_disp.sv
// two digit split and seven segment port patterns
`timescale 1ns / 1ps
`default_nettype none

module tla_disp (
	input  wire logic [tla_pkg::LEVEL_W-1:0] level,
	output logic      [tla_pkg::SEG_W-1:0]   tens_seg,
	output logic      [tla_pkg::SEG_W-1:0]   units_seg
);
	import tla_pkg::*;

	logic [DIGIT_W-1:0] tens;
	logic [LEVEL_W-1:0] tens_x10;
	logic [LEVEL_W-1:0] units_full;

	// tens digit by parallel compares, level never exceeds 99
	always_comb begin
		tens = '0;
		for (int k = 1; k <= 9; k++) begin
			if (level >= LEVEL_W'(k * 10)) begin
				tens = DIGIT_W'(k);
			end
		end
	end

	assign tens_x10   = (LEVEL_W'(tens) << 3) + (LEVEL_W'(tens) << 1);
	assign units_full = level - tens_x10;

	assign tens_seg  = seg_pattern(tens);
	assign units_seg = seg_pattern(units_full[DIGIT_W-1:0]);

endmodule

`default_nettype wire

### hw/rtl/tank_level_average_alarm.sv
// top level of the tank level averaging alarm
`timescale 1ns / 1ps
`default_nettype none

// tank level averaging alarm. each input word carries nine probe bits; the
// highest active probe gives a level of 5..99 percent (0 with no probe). the
// first WINDOW_SAMPLES words of a window are summed, the next word takes no
// sample and instead latches sum / WINDOW_SAMPLES as the shown level, sets
// the alarm when that level is at or below the threshold, and starts a new
// window. every input word gives exactly one output word with the shown
// level, the alarm, both digit port patterns and an updated flag on tuser.
// one word per clock sustained while m_tready holds high; on the way out a word passes
// an input register, then the accumulator with its reciprocal multiply and the
// segment decode feed the output register. the threshold is sampled only
// on an averaging word; before the first average level and alarm read 0.
module tank_level_average_alarm #(
	parameter int WINDOW_SAMPLES = 25
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,    // [8:0] probe_bits, rest zero
	// output stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [39:0] m_tdata,    // [6:0] shown_level, [7] alarm,
	                                     // [23:8] tens_segments, [39:24] units_segments
	output logic      [0:0]  m_tuser,    // [0] updated
	// threshold register
	input  wire logic        cfg_we,
	input  wire logic [6:0]  cfg_wdata   // alarm_threshold
);
	import tla_pkg::*;

	// input register
	logic               valid_s1;
	logic [PROBE_W-1:0] probe_s1;

	// output register
	logic               out_valid_q;
	logic [LEVEL_W-1:0] level_q;
	logic               alarm_q;
	logic [SEG_W-1:0]   tens_seg_q;
	logic [SEG_W-1:0]   units_seg_q;
	logic               updated_q;

	logic [LEVEL_W-1:0] threshold_q;
	logic               advance;
	logic               out_load;
	avg_result_t        avg_res;
	logic [SEG_W-1:0]   tens_seg;
	logic [SEG_W-1:0]   units_seg;

	// output slot free or draining this cycle
	assign advance  = !out_valid_q || m_tready;
	assign out_load = valid_s1 && advance;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESH_RESET;
		end else if (cfg_we) begin
			threshold_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			probe_s1 <= s_tdata[PROBE_W-1:0];
		end
	end

	// running sum, window count and latched average
	tla_accum #(
		.WINDOW_SAMPLES(WINDOW_SAMPLES)
	) u_accum (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (out_load),
		.sample_level(encode_level(probe_s1)),
		.threshold   (threshold_q),
		.result      (avg_res)
	);

	// digit patterns of the level shown after this word
	tla_disp u_disp (
		.level    (avg_res.level),
		.tens_seg (tens_seg),
		.units_seg(units_seg)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			level_q     <= avg_res.level;
			alarm_q     <= avg_res.alarm;
			tens_seg_q  <= tens_seg;
			units_seg_q <= units_seg;
			updated_q   <= avg_res.updated;
		end
	end

	assign m_tvalid   = out_valid_q;
	assign m_tdata    = {units_seg_q, tens_seg_q, alarm_q, level_q};
	assign m_tuser[0] = updated_q;

	logic [LEVEL_W-1:0] u_level_prev_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			u_level_prev_q <= '0;
		end else if (out_load) begin
			u_level_prev_q <= avg_res.level;
		end
	end

	// averaged level never leaves the percent range
	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[6:0] <= LEVEL_MAX))
		else $error("shown level above 99");

	// a stalled input word holds until the output side drains
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(probe_s1)))
		else $error("input register lost a stalled word");

	// level zero shows zero on both digits
	a_zero_digits: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tdata[6:0] == 7'd0)) |->
		((m_tdata[23:8] == seg_pattern(4'd0)) && (m_tdata[39:24] == seg_pattern(4'd0))))
		else $error("segment patterns disagree with level zero");

	// a word with no new average repeats the level of the word before it
	a_level_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && !avg_res.updated) |=> (level_q == $past(u_level_prev_q)))
		else $error("level changed without an averaging word");

endmodule

`default_nettype wire

### verif/tank_level_average_alarm_tb.sv
// self-checking testbench for the tank level averaging alarm
`timescale 1ns / 1ps

module tank_level_average_alarm_tb;

	import tla_pkg::*;

	localparam int WINDOW         = 25;
	localparam int TICKS_PER_AVG  = WINDOW + 1;
	localparam int SETTLE_CYCLES  = 6;      // pipeline is two deep, some margin
	localparam int QUIET_LIMIT    = 3000;   // cycles with no word moving on either side
	localparam int IDLE_NONE      = 0;
	localparam int IDLE_HEAVY     = 69;
	localparam int IDLE_MIXED     = 25;
	localparam int PHASE_WORDS    = 250;
	localparam int HOLD_AT_WORD   = 100;

	// one expected output word
	typedef struct {
		logic [LEVEL_W-1:0] level;
		logic               alarm;
		logic [SEG_W-1:0]   tens;
		logic [SEG_W-1:0]   units;
		logic               updated;
	} tank_report_t;

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata;
	logic                m_tvalid;
	logic                m_tready;
	logic [M_DATA_W-1:0] m_tdata;
	logic [0:0]          m_tuser;
	logic                cfg_we;
	logic [LEVEL_W-1:0]  cfg_wdata;

	tank_level_average_alarm #(
		.WINDOW_SAMPLES(WINDOW)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	// percent for each probe, lowest probe first
	int unsigned probe_percent [9] = '{5, 10, 20, 40, 50, 60, 80, 90, 99};
	// digit port patterns, digit 0 first
	logic [SEG_W-1:0] digit_port [10] = '{
		16'h8000, 16'hF330, 16'h4BDF, 16'h63DF, 16'h33FF,
		16'h26DF, 16'h07DF, 16'hF3DF, 16'h03DF, 16'h23DF
	};

	// predictor state
	int unsigned        ticks_in_window;
	int unsigned        percent_sum;
	logic [LEVEL_W-1:0] avg_level;
	logic               alarm_latched;
	logic [LEVEL_W-1:0] alarm_limit;

	tank_report_t pending_reports[$];

	// stimulus control and bookkeeping
	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	int unsigned words_sent;
	int unsigned reports_seen;
	int unsigned averages_seen;
	int unsigned alarms_seen;
	int unsigned limits_written;
	int unsigned fail_count;
	int unsigned quiet_cycles;
	int          band_lo;       // -1 selects uniform random probe bits
	int          band_hi;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// highest active probe decides the level
	function automatic int unsigned probe_to_percent(input logic [PROBE_W-1:0] bits);
		for (int b = PROBE_W - 1; b >= 0; b--) begin
			if (bits[b])
				return probe_percent[b];
		end
		return 0;
	endfunction

	// advance the predictor by one accepted probe word
	function tank_report_t predict_report(input logic [PROBE_W-1:0] bits);
		tank_report_t r;
		r.updated = 1'b0;
		if (ticks_in_window < WINDOW) begin
			percent_sum += probe_to_percent(bits);
			ticks_in_window++;
		end else begin
			// averaging tick: the probe word is dropped
			avg_level       = LEVEL_W'(percent_sum / WINDOW);
			alarm_latched   = (avg_level <= alarm_limit);
			percent_sum     = 0;
			ticks_in_window = 0;
			r.updated       = 1'b1;
		end
		r.level = avg_level;
		r.alarm = alarm_latched;
		r.tens  = digit_port[(avg_level / 10) % 10];
		r.units = digit_port[avg_level % 10];
		return r;
	endfunction

	// receiver: random back-pressure at the chosen stall rate
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// every accepted input word queues one expected output word
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			pending_reports.push_back(predict_report(s_tdata[PROBE_W-1:0]));
	end

	// compare each output word with the oldest expectation
	always @(posedge clk) begin
		tank_report_t want;
		if (arst_n && m_tvalid && m_tready) begin
			reports_seen++;
			if (pending_reports.size() == 0) begin
				$error("output word with nothing expected: tdata %h tuser %b", m_tdata, m_tuser);
				fail_count++;
			end else begin
				want = pending_reports.pop_front();
				if (m_tdata[6:0] !== want.level) begin
					$error("shown_level: expected %0d, got %0d", want.level, m_tdata[6:0]);
					fail_count++;
				end
				if (m_tdata[7] !== want.alarm) begin
					$error("alarm: expected %0b, got %0b", want.alarm, m_tdata[7]);
					fail_count++;
				end
				if (m_tdata[23:8] !== want.tens) begin
					$error("tens_segments: expected %h, got %h", want.tens, m_tdata[23:8]);
					fail_count++;
				end
				if (m_tdata[39:24] !== want.units) begin
					$error("units_segments: expected %h, got %h", want.units, m_tdata[39:24]);
					fail_count++;
				end
				if (m_tuser[0] !== want.updated) begin
					$error("updated: expected %0b, got %0b", want.updated, m_tuser[0]);
					fail_count++;
				end
				if (want.updated) begin
					averages_seen++;
					if (want.alarm)
						alarms_seen++;
				end
			end
		end
	end

	// watchdog on cycles where no word moves
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("watchdog expired with %0d words still expected", pending_reports.size());
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// send one probe word; entered and left at a falling edge
	task automatic send_probe(input logic [PROBE_W-1:0] bits);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {{(S_DATA_W - PROBE_W){1'b0}}, bits};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
		words_sent++;
	endtask

	// stop sending and let every expected word come out
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (pending_reports.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// threshold write, only while the block is drained
	task automatic write_alarm_limit(input logic [LEVEL_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		alarm_limit = value;
		limits_written++;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic send_repeated(input logic [PROBE_W-1:0] bits, input int count);
		repeat (count) send_probe(bits);
	endtask

	// new content band for the window about to start
	task automatic pick_band();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 4) begin
			band_lo = -1;
		end else if (pick < 9) begin
			band_lo = $urandom_range(0, 9);
			band_hi = band_lo + $urandom_range(0, 2);
			if (band_hi > 9)
				band_hi = 9;
		end else begin
			band_lo = 0;
			band_hi = 0;
		end
	endtask

	// probe word from the current band; lower probes random under the top one
	function automatic logic [PROBE_W-1:0] band_probe();
		int top;
		int below;
		if (band_lo < 0)
			return PROBE_W'($urandom_range(0, 511));
		top = $urandom_range(band_lo, band_hi);
		if (top == 0)
			return '0;
		below = (1 << (top - 1)) - 1;
		return PROBE_W'((1 << (top - 1)) | ($urandom & below));
	endfunction

	// level and alarm before the first average, every probe and the extremes
	task automatic test_directed_window();
		send_probe(9'h000);
		send_probe(9'h1FF);
		for (int b = 0; b < PROBE_W; b++)
			send_probe(PROBE_W'(1 << b));
		send_probe(9'h0FF);
		send_probe(9'h155);
		send_probe(9'h0AA);
		send_probe(9'h003);
		send_probe(9'h006);
		send_probe(9'h00C);
		send_probe(9'h018);
		send_probe(9'h030);
		send_probe(9'h060);
		send_probe(9'h0C0);
		send_probe(9'h180);
		send_probe(9'h101);
		send_probe(9'h011);
		send_probe(9'h022);
		// averaging tick, its probe bits must be dropped
		send_probe(9'h1FF);
		wait_drained();
	endtask

	// threshold at zero, above the level range, and exactly at full
	task automatic test_threshold_extremes();
		write_alarm_limit(7'd0);
		send_repeated(9'h000, TICKS_PER_AVG);   // average 0, alarm on
		send_repeated(9'h001, TICKS_PER_AVG);   // average 5, alarm off
		wait_drained();
		write_alarm_limit(7'd127);
		send_repeated(9'h100, TICKS_PER_AVG);   // full tank still alarms
		// threshold change mid-window: alarm holds until the next average
		send_repeated(9'h1FF, 13);
		wait_drained();
		write_alarm_limit(7'd0);
		send_repeated(9'h1FF, TICKS_PER_AVG - 13);
		wait_drained();
		write_alarm_limit(7'd99);
		send_repeated(9'h1FF, TICKS_PER_AVG);   // 99 at limit 99, alarm on
		wait_drained();
	endtask

	// random windows under one idle profile and one threshold
	task automatic test_random_phase(input int unsigned send_pct, input int unsigned stall_pct,
			input logic [LEVEL_W-1:0] limit);
		write_alarm_limit(limit);
		send_idle_pct  = send_pct;
		recv_stall_pct = stall_pct;
		for (int i = 0; i < PHASE_WORDS; i++) begin
			// sender holds off until the block has caught up
			if (i == HOLD_AT_WORD)
				wait_drained();
			if (words_sent % TICKS_PER_AVG == 0)
				pick_band();
			send_probe(band_probe());
		end
		wait_drained();
	endtask

	initial begin
		arst_n          = 1'b0;
		s_tvalid        = 1'b0;
		s_tdata         = '0;
		cfg_we          = 1'b0;
		cfg_wdata       = '0;
		send_idle_pct   = IDLE_NONE;
		recv_stall_pct  = IDLE_NONE;
		words_sent      = 0;
		reports_seen    = 0;
		averages_seen   = 0;
		alarms_seen     = 0;
		limits_written  = 0;
		fail_count      = 0;
		quiet_cycles    = 0;
		band_lo         = -1;
		band_hi         = 0;
		ticks_in_window = 0;
		percent_sum     = 0;
		avg_level       = '0;
		alarm_latched   = 1'b0;
		alarm_limit     = THRESH_RESET;

		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed_window();
		test_threshold_extremes();
		test_random_phase(IDLE_NONE, IDLE_NONE, LEVEL_W'($urandom_range(0, 99)));
		test_random_phase(IDLE_HEAVY, IDLE_NONE, 7'd50);
		test_random_phase(IDLE_NONE, IDLE_HEAVY, 7'd40);
		test_random_phase(IDLE_MIXED, IDLE_MIXED, LEVEL_W'($urandom_range(0, 127)));

		$display("sent %0d probe words, checked %0d output words", words_sent, reports_seen);
		$display("%0d averages (%0d with alarm on) across %0d threshold writes",
			averages_seen, alarms_seen, limits_written);
		if (fail_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("%0d mismatches", fail_count);
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
